[rtl/core/rau_pkg.sv]
// ---------------------------------------------------------------------------
// rau_pkg: shared codes for the rational arithmetic unit
// Command codes and the control bundle reported by the divider.
// ---------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_SUB  = 3'd1;
  localparam logic [2:0] CMD_MUL  = 3'd2;
  localparam logic [2:0] CMD_DIV  = 3'd3;
  localparam logic [2:0] CMD_LESS = 3'd4;
  localparam logic [2:0] CMD_EQ   = 3'd5;
  localparam logic [2:0] CMD_NORM = 3'd6;
  localparam logic [2:0] CMD_NONE = 3'd7;  // unused code, all-zero result

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage
`default_nettype wire

[rtl/core/rau_div.sv]
// ---------------------------------------------------------------------------
// rau_div: shared unsigned 64-bit divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module rau_div import rau_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire  [63:0] dividend,
  input  wire  [63:0] divisor,
  output div_ctl_t    ctl,
  output logic [63:0] quot,
  output logic [63:0] rem
);
  logic [63:0] q_r, q_nxt, r_r, r_nxt, d_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0] trial;
  logic [64:0] sh;

  always_comb begin
    sh = {r_r, q_r[63]};
    trial = sh - {1'b0, d_r};
    q_nxt = q_r; r_nxt = r_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      q_nxt = dividend; r_nxt = '0; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        r_nxt = trial[63:0];
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        r_nxt = sh[63:0];
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt;
    if (start) d_r <= divisor;
  end

  assign quot = q_r;
  assign rem  = r_r;
  assign ctl  = '{start: start, busy: busy_r, done: done_r};

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |=> busy_r || done_r) else $error("busy lost");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("spurious done");
endmodule
`default_nettype wire

[rtl/core/rational_arithmetic_unit.sv]
// ---------------------------------------------------------------------------
// rational_arithmetic_unit: fraction arithmetic with gcd reduction
// Cross-multiplies two fractions, reduces by Euclid on one shared divider.
// ---------------------------------------------------------------------------
// Sequence: compares and cmd 7 go from the product passes straight to output;
//   arithmetic giving 0/0 skips the divider; otherwise Euclid remainder steps and
//   the two divisions by g run, all on the one radix-2 divider.
// Throughput: one request at a time; in_tready is low while a request works.
// Result sits in an output register; the next request is taken once it goes.
// Reset: rst_n synchronous, active low, clears the sequencer and valid flag.
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // tdata: cmd[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99]
  input  wire  [135:0] in_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  // tdata: res_num[63:0], res_den[127:64], flag[128]
  output logic [135:0] out_tdata
);
  localparam logic [3:0] S_IDLE = 4'd0, S_MUL1 = 4'd1, S_MUL2 = 4'd2,
                         S_COMB = 4'd3, S_GCD  = 4'd4, S_GWAIT = 4'd5,
                         S_DN   = 4'd6, S_DNW  = 4'd7, S_DD   = 4'd8,
                         S_DDW  = 4'd9, S_FIN  = 4'd10, S_OUT = 4'd11;

  logic [3:0]  st_r, st_nxt;
  logic [2:0]  cmd_r;
  logic signed [31:0] an_r, ad_r, bn_r, bd_r;
  logic signed [63:0] p1_r, p2_r;   // registered products
  logic [63:0] n_r, d_r, x_r, y_r;
  logic [63:0] res_n_r, res_d_r;
  logic        flag_r, ov_r;

  // one shared 32x32 signed multiplier, operands chosen by the sequencer
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;

  logic        dv_start;
  logic [63:0] dv_a, dv_b, dv_q, dv_rm;
  div_ctl_t    dv_ctl;

  rau_div u_div (.clk, .rst_n, .start(dv_start), .dividend(dv_a), .divisor(dv_b),
                 .ctl(dv_ctl), .quot(dv_q), .rem(dv_rm));

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  always_comb begin
    ma = an_r; mb = bd_r;
    case (st_r)
      S_MUL1: begin
        case (cmd_r)
          CMD_MUL: begin ma = an_r; mb = bn_r; end
          default: begin ma = an_r; mb = bd_r; end
        endcase
      end
      S_MUL2: begin
        case (cmd_r)
          CMD_DIV: begin ma = ad_r; mb = bn_r; end
          CMD_MUL: begin ma = ad_r; mb = bd_r; end
          default: begin ma = ad_r; mb = bn_r; end
        endcase
      end
      default: begin ma = an_r; mb = bd_r; end
    endcase
    prod = ma * mb;
  end

  always_comb begin
    st_nxt = st_r; dv_start = 1'b0; dv_a = x_r; dv_b = y_r;
    case (st_r)
      S_IDLE:  if (in_tvalid) st_nxt = S_MUL1;
      S_MUL1:  st_nxt = S_MUL2;
      S_MUL2:  st_nxt = S_COMB;
      S_COMB: begin
        if (cmd_r == CMD_LESS || cmd_r == CMD_EQ || cmd_r == CMD_NONE) st_nxt = S_OUT;
        else if (ov_r) st_nxt = S_MUL2; // add/sub: third product pass
        else st_nxt = S_GCD;
      end
      S_GCD: begin
        if (y_r == 64'd0) st_nxt = (x_r == 64'd0) ? S_FIN : S_DN;
        else begin dv_start = 1'b1; st_nxt = S_GWAIT; end
      end
      S_GWAIT: if (dv_ctl.done) st_nxt = S_GCD;
      S_DN:    begin dv_start = 1'b1; dv_a = mag64(n_r); dv_b = x_r; st_nxt = S_DNW; end
      S_DNW:   if (dv_ctl.done) st_nxt = S_DD;
      S_DD:    begin dv_start = 1'b1; dv_a = mag64(d_r); dv_b = x_r; st_nxt = S_DDW; end
      S_DDW:   if (dv_ctl.done) st_nxt = S_FIN;
      S_FIN:   st_nxt = S_OUT;
      S_OUT:   if (out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_MUL1) ov_r <= (cmd_r == CMD_ADD || cmd_r == CMD_SUB);
      else if (st_r == S_COMB) ov_r <= 1'b0;
    end
    case (st_r)
      S_IDLE: if (in_tvalid) begin
        cmd_r <= in_tdata[2:0];
        an_r <= in_tdata[34:3];  ad_r <= in_tdata[66:35];
        bn_r <= in_tdata[98:67]; bd_r <= in_tdata[130:99];
      end
      S_MUL1: p1_r <= prod;
      // first add/sub visit gives ad*bn, the rerun ad*bd
      S_MUL2: p2_r <= prod;
      S_COMB: begin
        flag_r <= 1'b0; res_n_r <= '0; res_d_r <= '0;
        case (cmd_r)
          CMD_ADD, CMD_SUB: begin
            if (ov_r) begin
              n_r <= (cmd_r == CMD_ADD) ? (p1_r + p2_r) : (p1_r - p2_r);
              bn_r <= bd_r; // next MUL2 pass forms ad*bd
            end else begin
              d_r <= p2_r;
              x_r <= mag64(n_r); y_r <= mag64(p2_r);
            end
          end
          CMD_MUL, CMD_DIV: begin
            n_r <= p1_r; d_r <= p2_r; x_r <= mag64(p1_r); y_r <= mag64(p2_r);
          end
          CMD_NORM: begin
            n_r <= 64'(signed'(an_r)); d_r <= 64'(signed'(ad_r));
            x_r <= mag64(64'(signed'(an_r))); y_r <= mag64(64'(signed'(ad_r)));
          end
          CMD_LESS: flag_r <= (p1_r < p2_r);
          CMD_EQ:   flag_r <= (ad_r != 0) && (bd_r != 0) && (an_r == bn_r) &&
                              (ad_r == bd_r);
          default: ;
        endcase
      end
      S_GWAIT: if (dv_ctl.done) begin x_r <= y_r; y_r <= dv_rm; end
      S_DNW: if (dv_ctl.done) n_r <= n_r[63] ? (64'd0 - dv_q) : dv_q;
      S_DDW: if (dv_ctl.done) d_r <= d_r[63] ? (64'd0 - dv_q) : dv_q;
      S_FIN: begin
        res_n_r <= d_r[63] ? (64'd0 - n_r) : n_r;
        res_d_r <= d_r[63] ? (64'd0 - d_r) : d_r;
      end
      default: ;
    endcase
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {7'd0, flag_r, res_d_r, res_n_r};

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("overlap");
  a_den_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_d_r[63] |-> res_d_r == 64'h8000000000000000)
    else $error("negative denominator");
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (cmd_r == CMD_LESS || cmd_r == CMD_EQ) |-> res_n_r == 64'd0)
    else $error("compare result not zero");
endmodule
`default_nettype wire

[verif/tb_rational_arithmetic_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rational_arithmetic_unit: self-checking bench for the fraction unit
// Directed and random requests are queued, sent with random sender gaps and
// receiver stalls in several phases, and every result is checked field by
// field against a local predictor of the cross-multiply and gcd reduction.
// ---------------------------------------------------------------------------
module tb_rational_arithmetic_unit import rau_pkg::*;;

  localparam int N_RANDOM    = 800;
  localparam int CYCLE_LIMIT = 30_000_000;
  localparam int DRAIN_CYC   = 10;

  typedef struct {
    logic        [2:0]  cmd;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
    int                 phase;
  } frac_req_t;

  typedef struct {
    logic [63:0] res_num;
    logic [63:0] res_den;
    logic        flag;
  } frac_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // tdata: cmd[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99]
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // tdata: res_num[63:0], res_den[127:64], flag[128]
  logic [135:0] out_tdata;

  frac_req_t pending_reqs[$];
  frac_res_t expected_fracs[$];
  int        n_errors = 0;
  int        cycle_count = 0;
  int        cur_phase = 0;
  int        send_idle_pct[4] = '{0, 62, 0, 22};
  int        recv_stall_pct[4] = '{0, 0, 62, 22};

  rational_arithmetic_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] magnitude(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Exact division of a signed value by a positive gcd, sign kept.
  function automatic logic [63:0] div_by_gcd(input logic [63:0] v, input logic [63:0] g);
    logic [63:0] q;
    q = magnitude(v) / g;
    return v[63] ? (64'd0 - q) : q;
  endfunction

  function automatic frac_res_t rational_result(input frac_req_t rq);
    logic [63:0] an, ad, bn, bd, n, d, x, y, r;
    logic        arith;
    frac_res_t   res;
    an = {{32{rq.a_num[31]}}, rq.a_num};
    ad = {{32{rq.a_den[31]}}, rq.a_den};
    bn = {{32{rq.b_num[31]}}, rq.b_num};
    bd = {{32{rq.b_den[31]}}, rq.b_den};
    n = '0; d = '0; res.flag = 1'b0; arith = 1'b1;
    case (rq.cmd)
      CMD_ADD:  begin n = an * bd + ad * bn; d = ad * bd; end
      CMD_SUB:  begin n = an * bd - ad * bn; d = ad * bd; end
      CMD_MUL:  begin n = an * bn; d = ad * bd; end
      CMD_DIV:  begin n = an * bd; d = ad * bn; end
      CMD_LESS: begin
        arith = 1'b0;
        res.flag = $signed(an * bd) < $signed(ad * bn);
      end
      CMD_EQ: begin
        arith = 1'b0;
        res.flag = (ad != 0) && (bd != 0) && (an == bn) && (ad == bd);
      end
      CMD_NORM: begin n = an; d = ad; end
      default:  arith = 1'b0;  // unused code: all zero
    endcase
    if (arith) begin
      // Euclid on magnitudes; gcd(x,0) = x, so 0/0 keeps g = 0
      x = magnitude(n);
      y = magnitude(d);
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      if (x != 0) begin
        n = div_by_gcd(n, x);
        d = div_by_gcd(d, x);
      end
      if (d[63]) begin
        n = 64'd0 - n;
        d = 64'd0 - d;
      end
    end
    res.res_num = n;
    res.res_den = d;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    n_errors++;
  endtask

  function automatic logic [31:0] rand_operand();
    logic [31:0] corner[5] = '{32'h8000_0000, 32'h8000_0001, 32'h7fff_ffff, 32'd0, 32'd1};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 40) - 20;     // small: lots of reduction
      4, 5, 6:    return $urandom;
      7:          return corner[$urandom_range(0, 4)];
      default:    return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
    endcase
  endfunction

  task automatic queue_req(input logic [2:0] c, input logic [31:0] an, input logic [31:0] ad,
                           input logic [31:0] bn, input logic [31:0] bd, input int ph);
    frac_req_t rq;
    rq.cmd = c; rq.a_num = an; rq.a_den = ad; rq.b_num = bn; rq.b_den = bd;
    rq.phase = ph;
    pending_reqs = {pending_reqs, rq};
  endtask

  // Driver: next request goes out once the current one has been taken.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_fracs = {expected_fracs, rational_result(pending_reqs[0])};
        void'(pending_reqs.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 &&
            $urandom_range(0, 99) >= send_idle_pct[pending_reqs[0].phase]) begin
          in_tdata  <= {5'd0, pending_reqs[0].b_den, pending_reqs[0].b_num,
                        pending_reqs[0].a_den, pending_reqs[0].a_num, pending_reqs[0].cmd};
          in_tvalid <= 1'b1;
          cur_phase <= pending_reqs[0].phase;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, checks each result against the oldest expectation.
  always @(posedge clk) begin
    frac_res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_fracs.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[63:0], 64'd0);
        end else begin
          want = expected_fracs.pop_front();
          if (out_tdata[63:0] !== want.res_num)
            report_mismatch("res_num", out_tdata[63:0], want.res_num);
          if (out_tdata[127:64] !== want.res_den)
            report_mismatch("res_den", out_tdata[127:64], want.res_den);
          if (out_tdata[128] !== want.flag)
            report_mismatch("flag", {63'd0, out_tdata[128]}, {63'd0, want.flag});
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct[cur_phase]);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d requests pending", pending_reqs.size());
      $display("** rational_arithmetic_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [2:0]  c;
    logic [31:0] an, ad, bn, bd;
    // directed: every command, extremes, both-zero, zero denominators, -2^31
    queue_req(CMD_ADD,  32'd1, 32'd2, 32'd1, 32'd3, 0);
    queue_req(CMD_SUB,  32'd1, 32'd2, 32'd1, 32'd2, 0);
    queue_req(CMD_MUL,  32'd6, -32'sd4, 32'd2, 32'd9, 0);
    queue_req(CMD_DIV,  32'd3, 32'd5, -32'sd6, 32'd10, 0);
    queue_req(CMD_LESS, 32'd1, 32'd3, 32'd1, 32'd2, 0);
    queue_req(CMD_LESS, 32'd1, 32'd2, 32'd1, 32'd3, 0);
    queue_req(CMD_EQ,   32'd4, 32'd7, 32'd4, 32'd7, 0);
    queue_req(CMD_EQ,   32'd0, 32'd0, 32'd0, 32'd0, 0);
    queue_req(CMD_NORM, 32'd12, -32'sd18, 32'd0, 32'd0, 0);
    queue_req(CMD_NORM, 32'd0, 32'd0, 32'd5, 32'd5, 0);
    queue_req(CMD_NORM, -32'sd7, 32'd0, 32'd0, 32'd0, 0);
    queue_req(CMD_NORM, 32'd9, 32'd0, 32'd0, 32'd0, 0);
    queue_req(CMD_ADD,  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    queue_req(CMD_SUB,  32'h8000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001, 0);
    queue_req(CMD_ADD,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    queue_req(CMD_SUB,  32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
    queue_req(CMD_MUL,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    queue_req(CMD_DIV,  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 0);
    queue_req(CMD_NORM, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 0);
    queue_req(CMD_LESS, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1, 0);
    queue_req(CMD_DIV,  32'd5, 32'd3, 32'd0, 32'd7, 0);
    queue_req(CMD_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      c  = 3'($urandom_range(0, 7));
      an = rand_operand(); ad = rand_operand();
      bn = rand_operand(); bd = rand_operand();
      if (c == CMD_EQ && $urandom_range(0, 1)) begin
        bn = an; bd = ad;      // make equality hits likely
      end
      queue_req(c, an, ad, bn, bd, (i * 4) / N_RANDOM);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() == 0 && expected_fracs.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_errors == 0) begin
      $display("** rational_arithmetic_unit: PASSED **");
    end else begin
      $display("** rational_arithmetic_unit: FAILED **");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/rau_pkg.sv
rtl/core/rau_div.sv
rtl/core/rational_arithmetic_unit.sv
verif/tb_rational_arithmetic_unit.sv
